// File: design/mrpf_pkg.sv
// Shared constants, widths and the controller-to-datapath command struct
// for the median radius point filter. No dependencies.
package mrpf_pkg;

  localparam int MAX_POINTS   = 64;
  localparam int AW           = $clog2(MAX_POINTS);
  localparam int CW           = $clog2(MAX_POINTS + 1);
  localparam int COORD_W      = 32;
  localparam int RADIUS_W     = 31;
  localparam int MED_W        = 33;
  localparam int MAG_W        = 34;
  localparam int HALF_W       = 17;
  localparam int PROD_W       = 2 * HALF_W;
  localparam int SQ_W         = 68;
  localparam int SUM_W        = 70;
  localparam int LIM_W        = 64;
  localparam int IDX_W        = 6;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(1000000);

  typedef struct packed {
    logic          wr_en;
    logic [AW-1:0] addr;
    logic          cand_ld;
    logic          cnt_clr;
    logic          cmp_en;
    logic          decide;
    logic          med_ld;
    logic [CW-1:0] n;
    logic          diff_en;
    logic          mul_en;
    logic          sq_en;
    logic          keep_en;
  } mrpf_cmd_t;

  typedef struct packed {
    logic keep;
  } mrpf_stat_t;

endpackage

// File: design/mrpf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mrpf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/mrpf_datapath.sv
// Datapath: point stores, rank counting for the medians, squared-distance
// verdict pipeline and radius register. Depends on mrpf_pkg and mrpf_ram.
module mrpf_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [mrpf_pkg::COORD_W-1:0]    east_mm,
  input  logic [mrpf_pkg::COORD_W-1:0]    north_mm,
  input  logic                            cfg_wr_en,
  input  logic [mrpf_pkg::RADIUS_W-1:0]   cfg_wr_data,
  input  mrpf_pkg::mrpf_cmd_t             cmd,
  output mrpf_pkg::mrpf_stat_t            stat
);
  import mrpf_pkg::*;

  logic [COORD_W-1:0] re, rn;
  logic [RADIUS_W-1:0] radius_r;
  logic [LIM_W-1:0]    lim_r;
  logic [COORD_W:0]    dbl;
  logic signed [COORD_W-1:0] ce_r, cn_r;
  logic [CW-1:0] lt_e_r, le_e_r, lt_n_r, le_n_r;
  logic [CW-1:0] lo_k, hi_k;
  logic signed [COORD_W-1:0] lo_e_r, hi_e_r, lo_n_r, hi_n_r;
  logic signed [MED_W-1:0]   med_e_r, med_n_r;
  logic signed [MAG_W-1:0]   dx, dy;
  logic [MAG_W-1:0]  mag_x_r, mag_y_r;
  logic [PROD_W-1:0] px00_r, px01_r, px11_r, py00_r, py01_r, py11_r;
  logic [SQ_W-1:0]   sq_x_r, sq_y_r;
  logic [SUM_W-1:0]  dist_sum;
  logic              keep_r;

  mrpf_ram #(.WIDTH(COORD_W), .DEPTH(MAX_POINTS)) u_east (
    .clk(clk), .we(cmd.wr_en), .waddr(cmd.addr), .wdata(east_mm),
    .raddr(cmd.addr), .rdata(re)
  );

  mrpf_ram #(.WIDTH(COORD_W), .DEPTH(MAX_POINTS)) u_north (
    .clk(clk), .we(cmd.wr_en), .waddr(cmd.addr), .wdata(north_mm),
    .raddr(cmd.addr), .rdata(rn)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RESET;
    end else if (cfg_wr_en) begin
      radius_r <= cfg_wr_data;
    end
  end

  // (2r)^2 stays below 2^64; refreshed every cycle from the register
  assign dbl = {1'b0, radius_r, 1'b0};
  always_ff @(posedge clk) begin
    lim_r <= dbl[COORD_W-1:0] * dbl[COORD_W-1:0];
  end

  // Element v is the k-th smallest when lt <= k < le
  assign lo_k = (cmd.n - CW'(1)) >> 1;
  assign hi_k = cmd.n >> 1;

  always_ff @(posedge clk) begin
    if (cmd.cand_ld) begin
      ce_r <= $signed(re);
      cn_r <= $signed(rn);
    end
    if (cmd.cnt_clr) begin
      lt_e_r <= '0;
      le_e_r <= '0;
      lt_n_r <= '0;
      le_n_r <= '0;
    end else if (cmd.cmp_en) begin
      lt_e_r <= lt_e_r + CW'($signed(re) <  ce_r);
      le_e_r <= le_e_r + CW'($signed(re) <= ce_r);
      lt_n_r <= lt_n_r + CW'($signed(rn) <  cn_r);
      le_n_r <= le_n_r + CW'($signed(rn) <= cn_r);
    end
    if (cmd.decide) begin
      if (lt_e_r <= lo_k && lo_k < le_e_r) lo_e_r <= ce_r;
      if (lt_e_r <= hi_k && hi_k < le_e_r) hi_e_r <= ce_r;
      if (lt_n_r <= lo_k && lo_k < le_n_r) lo_n_r <= cn_r;
      if (lt_n_r <= hi_k && hi_k < le_n_r) hi_n_r <= cn_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      med_e_r <= '0;
      med_n_r <= '0;
    end else if (cmd.med_ld) begin
      med_e_r <= MED_W'(lo_e_r) + MED_W'(hi_e_r);
      med_n_r <= MED_W'(lo_n_r) + MED_W'(hi_n_r);
    end
  end

  // Offsets at twice scale, then magnitude split into 17-bit halves
  assign dx = {re[COORD_W-1], re, 1'b0} - MAG_W'(med_e_r);
  assign dy = {rn[COORD_W-1], rn, 1'b0} - MAG_W'(med_n_r);

  always_ff @(posedge clk) begin
    if (cmd.diff_en) begin
      mag_x_r <= dx[MAG_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
      mag_y_r <= dy[MAG_W-1] ? MAG_W'(-dy) : MAG_W'(dy);
    end
    if (cmd.mul_en) begin
      px00_r <= mag_x_r[HALF_W-1:0] * mag_x_r[HALF_W-1:0];
      px01_r <= mag_x_r[HALF_W-1:0] * mag_x_r[MAG_W-1:HALF_W];
      px11_r <= mag_x_r[MAG_W-1:HALF_W] * mag_x_r[MAG_W-1:HALF_W];
      py00_r <= mag_y_r[HALF_W-1:0] * mag_y_r[HALF_W-1:0];
      py01_r <= mag_y_r[HALF_W-1:0] * mag_y_r[MAG_W-1:HALF_W];
      py11_r <= mag_y_r[MAG_W-1:HALF_W] * mag_y_r[MAG_W-1:HALF_W];
    end
    if (cmd.sq_en) begin
      sq_x_r <= (SQ_W'(px11_r) << (2 * HALF_W)) + (SQ_W'(px01_r) << (HALF_W + 1))
              + SQ_W'(px00_r);
      sq_y_r <= (SQ_W'(py11_r) << (2 * HALF_W)) + (SQ_W'(py01_r) << (HALF_W + 1))
              + SQ_W'(py00_r);
    end
    if (cmd.keep_en) begin
      keep_r <= dist_sum <= SUM_W'(lim_r);
    end
  end

  assign dist_sum  = SUM_W'(sq_x_r) + SUM_W'(sq_y_r);
  assign stat.keep = keep_r;

endmodule

// File: design/mrpf_ctrl.sv
// Controller: load, median rank sweeps and verdict sequencing, plus the
// result register. Depends on mrpf_pkg.
module mrpf_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          final_point,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mrpf_pkg::IDX_W-1:0]    point_index,
  output logic                          last_verdict,
  output mrpf_pkg::mrpf_cmd_t           cmd
);
  import mrpf_pkg::*;

  typedef enum logic [3:0] {
    S_LOAD, S_CAND, S_LATCH, S_SWEEP, S_DRAIN, S_DECIDE, S_MED,
    S_VRD, S_VDIFF, S_VMUL, S_VSQ, S_VKEEP, S_VOUT
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt, i_r, i_nxt, j_r, j_nxt;
  logic          cmp_vld_r, cmp_vld_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic          last_r, last_nxt;
  logic          i_last;

  assign i_last = (i_r == cnt_r - CW'(1));

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    cmp_vld_nxt   = 1'b0;
    out_valid_nxt = out_valid_r;
    idx_nxt       = idx_r;
    last_nxt      = last_r;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.n         = cnt_r;
    cmd.cmp_en    = cmp_vld_r;
    cmd.addr      = i_r[AW-1:0];
    case (state_r)
      S_LOAD: begin
        in_ready   = 1'b1;
        cmd.addr   = cnt_r[AW-1:0];
        cmd.wr_en  = in_valid;
        if (in_valid) begin
          cnt_nxt = cnt_r + CW'(1);
          if (final_point || cnt_r == CW'(MAX_POINTS - 1)) begin
            i_nxt     = '0;
            state_nxt = S_CAND;
          end
        end
      end
      S_CAND: state_nxt = S_LATCH;
      S_LATCH: begin
        cmd.cand_ld = 1'b1;
        cmd.cnt_clr = 1'b1;
        j_nxt       = '0;
        state_nxt   = S_SWEEP;
      end
      S_SWEEP: begin
        cmd.addr    = j_r[AW-1:0];
        cmp_vld_nxt = 1'b1;
        j_nxt       = j_r + CW'(1);
        if (j_r == cnt_r - CW'(1)) state_nxt = S_DRAIN;
      end
      S_DRAIN: state_nxt = S_DECIDE;
      S_DECIDE: begin
        cmd.decide = 1'b1;
        if (i_last) begin
          i_nxt     = '0;
          state_nxt = S_MED;
        end else begin
          i_nxt     = i_r + CW'(1);
          state_nxt = S_CAND;
        end
      end
      S_MED: begin
        cmd.med_ld = 1'b1;
        state_nxt  = S_VRD;
      end
      S_VRD: state_nxt = S_VDIFF;
      S_VDIFF: begin
        cmd.diff_en = 1'b1;
        state_nxt   = S_VMUL;
      end
      S_VMUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = S_VSQ;
      end
      S_VSQ: begin
        cmd.sq_en = 1'b1;
        state_nxt = S_VKEEP;
      end
      S_VKEEP: begin
        cmd.keep_en   = 1'b1;
        out_valid_nxt = 1'b1;
        idx_nxt       = i_r[IDX_W-1:0];
        last_nxt      = i_last;
        state_nxt     = S_VOUT;
      end
      S_VOUT: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          if (i_last) begin
            cnt_nxt   = '0;
            state_nxt = S_LOAD;
          end else begin
            i_nxt     = i_r + CW'(1);
            state_nxt = S_VRD;
          end
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cnt_r       <= '0;
      i_r         <= '0;
      j_r         <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      last_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
      last_r      <= last_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign point_index  = idx_r;
  assign last_verdict = last_r;

endmodule

// File: design/median_radius_point_filter.sv
// Top level of the median radius point filter: controller plus datapath.
// Depends on mrpf_pkg, mrpf_ctrl, mrpf_datapath (and mrpf_ram below it).
//
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------------------
//  in       | in_valid / in_ready    | in_east_mm, in_north_mm, in_final_point
//  out      | out_valid / out_ready  | out_point_index, out_keep, out_last_verdict
//  cfg      | cfg_wr_en              | cfg_wr_data (max radius, mm)
//
// Points load one per cycle while in_ready is high. On the closing point (or
// the 64th) the medians come from one rank sweep of n store reads per
// candidate point. Each verdict then runs the squared-distance pipeline and
// holds the result until out_ready is high.
// No request is taken while a set is being judged. Reset is synchronous.
module median_radius_point_filter (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [mrpf_pkg::COORD_W-1:0]    in_east_mm,
  input  logic [mrpf_pkg::COORD_W-1:0]    in_north_mm,
  input  logic                            in_final_point,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [mrpf_pkg::IDX_W-1:0]      out_point_index,
  output logic                            out_keep,
  output logic                            out_last_verdict,
  input  logic                            cfg_wr_en,
  input  logic [mrpf_pkg::RADIUS_W-1:0]   cfg_wr_data
);
  import mrpf_pkg::*;

  mrpf_cmd_t  cmd;
  mrpf_stat_t stat;

  mrpf_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .final_point(in_final_point),
    .out_valid(out_valid), .out_ready(out_ready),
    .point_index(out_point_index), .last_verdict(out_last_verdict),
    .cmd(cmd)
  );

  mrpf_datapath u_dp (
    .clk(clk), .rst_n(rst_n),
    .east_mm(in_east_mm), .north_mm(in_north_mm),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .cmd(cmd), .stat(stat)
  );

  assign out_keep = stat.keep;

endmodule
